@@ hdl/bmls_pkg.sv @@
// ----------------------------------------------------------------------------
// bmls_pkg
// Shared constants for the byte-addressed load/store data memory: operation
// codes, byte-lane count and the fill value of the store after reset.
// ----------------------------------------------------------------------------
package bmls_pkg;

  localparam int unsigned MEM_BYTES_DEF = 4096;
  localparam int unsigned NUM_LANES     = 4;

  localparam logic [7:0] RESET_BYTE = 8'ha5;

  typedef logic [2:0] op_t;

  localparam op_t OP_LBU = 3'd0;
  localparam op_t OP_LHU = 3'd1;
  localparam op_t OP_LW  = 3'd2;
  localparam op_t OP_LB  = 3'd3;
  localparam op_t OP_LH  = 3'd4;
  localparam op_t OP_SB  = 3'd5;
  localparam op_t OP_SH  = 3'd6;
  localparam op_t OP_SW  = 3'd7;

endpackage

@@ hdl/byte_memory_load_store.sv @@
// ----------------------------------------------------------------------------
// byte_memory_load_store
// Little-endian byte-addressed data memory with byte, half and word loads
// (zero- or sign-extended) and stores, unaligned, split over four byte lanes.
// ----------------------------------------------------------------------------
// Results go through the read stage and then the output register.
// Throughput: one access per cycle when not stalled; the four byte-lane banks
// each take one read or write per cycle, so any access touches each lane at most once.
// Reset: after rst_n, a fill pass writes 0xa5 to every row of the lane banks,
// MEM_SIZE/4 rows (1024 at the default size), with in_stall held high.
module byte_memory_load_store #(
  parameter int unsigned MEM_BYTES = bmls_pkg::MEM_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  bmls_pkg::op_t    in_operation,
  input  logic [31:0]      in_address,
  input  logic [31:0]      in_write_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_read_data,
  output logic             out_out_of_range
);
  import bmls_pkg::*;

  localparam int unsigned MEM_SIZE = ((MEM_BYTES + 15) / 16) * 16;
  localparam int unsigned ROWS     = MEM_SIZE / NUM_LANES;
  localparam int unsigned RIDX_W   = $clog2(ROWS);
  localparam logic [29:0]       ROWS_C    = 30'(ROWS);
  localparam logic [RIDX_W-1:0] ROWS_LAST = RIDX_W'(ROWS - 1);

  // fill pass
  logic              clearing_r;
  logic [RIDX_W-1:0] clr_row_r;
  logic [RIDX_W-1:0] clr_row_nxt;

  // accept stage
  logic              in_acc;
  logic              is_store;
  logic [2:0]        nbytes;
  logic [29:0]       row_lo;
  logic [29:0]       row_hi;
  logic [3:0]        lane_active;
  logic [3:0]        lane_inr;
  logic [RIDX_W-1:0] lane_row [NUM_LANES];
  logic [7:0]        lane_wdata [NUM_LANES];
  logic              acc_oor;

  // memory ports
  logic [NUM_LANES-1:0] mem_we;
  logic [RIDX_W-1:0]    mem_addr [NUM_LANES];
  logic [7:0]           mem_wdata [NUM_LANES];
  logic [7:0]           rd_data_r [NUM_LANES];

  // read stage
  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [1:0]  s1_lo_r;
  logic [3:0]  s1_ok_r;
  logic        s1_oor_r;
  logic        s1_move;
  logic [31:0] s1_data;

  // output register
  logic        out_valid_r;
  logic [31:0] out_read_data_r;
  logic        out_oor_r;

  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_valid_r && !s1_move);
  assign in_acc   = in_valid && !in_stall;

  assign is_store = (in_operation == OP_SB) || (in_operation == OP_SH) ||
                    (in_operation == OP_SW);

  always_comb begin
    case (in_operation)
      OP_LBU, OP_LB, OP_SB: nbytes = 3'd1;
      OP_LHU, OP_LH, OP_SH: nbytes = 3'd2;
      default:              nbytes = 3'd4;
    endcase
  end

  assign row_lo = in_address[31:2];
  assign row_hi = in_address[31:2] + 30'd1;

  // Map each lane to the access byte it carries; lanes below the start
  // offset hold bytes that spilled into the next row.
  always_comb begin
    logic [1:0]  k;
    logic [29:0] row;
    for (int l = 0; l < NUM_LANES; l++) begin
      k              = 2'(l) - in_address[1:0];
      row            = (2'(l) < in_address[1:0]) ? row_hi : row_lo;
      lane_active[l] = {1'b0, k} < nbytes;
      lane_inr[l]    = row < ROWS_C;
      lane_row[l]    = row[RIDX_W-1:0];
      lane_wdata[l]  = in_write_data[8*k +: 8];
    end
  end

  assign acc_oor = |(lane_active & ~lane_inr);

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (clearing_r) begin
        mem_we[l]    = 1'b1;
        mem_addr[l]  = clr_row_r;
        mem_wdata[l] = RESET_BYTE;
      end else begin
        mem_we[l]    = in_acc && is_store && lane_active[l] && lane_inr[l];
        mem_addr[l]  = lane_row[l];
        mem_wdata[l] = lane_wdata[l];
      end
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    logic [7:0] bank_mem [ROWS];

    always_ff @(posedge clk) begin
      if (mem_we[g]) begin
        bank_mem[mem_addr[g]] <= mem_wdata[g];
      end
      // hold read data while the read stage waits
      if (in_acc) begin
        rd_data_r[g] <= bank_mem[mem_addr[g]];
      end
    end
  end

  assign clr_row_nxt = clr_row_r + RIDX_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_row_r  <= '0;
    end else if (clearing_r) begin
      clr_row_r <= clr_row_nxt;
      if (clr_row_r == ROWS_LAST) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_operation;
      s1_lo_r  <= in_address[1:0];
      s1_ok_r  <= is_store ? 4'b0000 : (lane_active & lane_inr);
      s1_oor_r <= acc_oor;
    end
  end

  // Gather bytes back into access order and extend.
  always_comb begin
    logic [1:0]  lane;
    logic [31:0] raw;
    raw = '0;
    for (int k = 0; k < NUM_LANES; k++) begin
      lane = s1_lo_r + 2'(k);
      raw[8*k +: 8] = s1_ok_r[lane] ? rd_data_r[lane] : 8'h00;
    end
    case (s1_op_r)
      OP_LB:   s1_data = {{24{raw[7]}}, raw[7:0]};
      OP_LH:   s1_data = {{16{raw[15]}}, raw[15:0]};
      default: s1_data = raw;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_read_data_r <= s1_data;
      out_oor_r       <= s1_oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_out_of_range = out_oor_r;

  a_fill_done_sticks : assert property (@(posedge clk) disable iff (!rst_n)
    !clearing_r |=> !clearing_r)
    else $error("fill pass restarted without reset");

  a_no_accept_in_fill : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !clearing_r)
    else $error("beat taken during fill pass");

  a_read_stage_held : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("read stage dropped while output stalled");

endmodule

@@ dv/mem_access_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mem_access_checker
// Watches the access and result channels of the byte-addressed data memory,
// keeps its own image of the byte store, predicts read data and the range
// flag for every accepted access, and compares each result beat in order.
// ----------------------------------------------------------------------------
module mem_access_checker #(
  parameter int unsigned MEM_BYTES = bmls_pkg::MEM_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  bmls_pkg::op_t in_operation,
  input  logic [31:0]   in_address,
  input  logic [31:0]   in_write_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  logic [31:0]   out_read_data,
  input  logic          out_out_of_range,
  output int            fail_count,
  output int            pending,
  output int            result_count,
  output int            oor_count
);
  import bmls_pkg::*;

  localparam int unsigned MEM_SIZE = (MEM_BYTES + 15) / 16 * 16;

  typedef struct packed {
    logic [31:0] read_data;
    logic        out_of_range;
  } access_result_t;

  logic [7:0]     mem_image [MEM_SIZE];
  access_result_t expected_results [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    result_count = 0;
    oor_count    = 0;
  end

  // Apply one access to the byte image and return what the memory should answer.
  function automatic access_result_t apply_access(op_t op, logic [31:0] addr,
                                                  logic [31:0] wdata);
    access_result_t res;
    int unsigned    nbytes;
    logic [31:0]    byte_addr;
    logic           is_store;
    res.read_data    = '0;
    res.out_of_range = 1'b0;
    is_store = (op == OP_SB) || (op == OP_SH) || (op == OP_SW);
    case (op)
      OP_LBU, OP_LB, OP_SB: nbytes = 1;
      OP_LHU, OP_LH, OP_SH: nbytes = 2;
      default:              nbytes = 4;
    endcase
    for (int k = 0; k < nbytes; k++) begin
      // byte addresses wrap modulo 2^32
      byte_addr = addr + 32'(k);
      if (byte_addr >= MEM_SIZE) begin
        res.out_of_range = 1'b1;
      end else if (is_store) begin
        mem_image[byte_addr] = wdata[8*k +: 8];
      end else begin
        res.read_data[8*k +: 8] = mem_image[byte_addr];
      end
    end
    if (op == OP_LB) begin
      res.read_data = {{24{res.read_data[7]}}, res.read_data[7:0]};
    end
    if (op == OP_LH) begin
      res.read_data = {{16{res.read_data[15]}}, res.read_data[15:0]};
    end
    return res;
  endfunction

  always @(posedge clk) begin
    access_result_t exp_res;
    if (!rst_n) begin
      foreach (mem_image[i]) mem_image[i] = RESET_BYTE;
      expected_results.delete();
    end else begin
      // check the result beat first: it always belongs to an older access
      if (out_valid && !out_stall) begin
        result_count++;
        if (out_out_of_range === 1'b1) oor_count++;
        if (expected_results.size() == 0) begin
          $error("result beat with no access pending: read_data=%h out_of_range=%b",
                 out_read_data, out_out_of_range);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_read_data !== exp_res.read_data) begin
            $error("read_data: expected %h, got %h", exp_res.read_data, out_read_data);
            fail_count++;
          end
          if (out_out_of_range !== exp_res.out_of_range) begin
            $error("out_of_range: expected %b, got %b", exp_res.out_of_range,
                   out_out_of_range);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_access(in_operation, in_address, in_write_data));
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ dv/tb_byte_memory_load_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_memory_load_store
// Drives loads and stores of every width into the data memory: a directed
// pass over sign extension, unaligned and partial out-of-range accesses and
// address wrap, then random accesses clustered so loads hit stored data.
// Both channels idle in random bursts; the result side is held off once for
// a long stretch. Checking is done by mem_access_checker.
// ----------------------------------------------------------------------------
module tb_byte_memory_load_store;
  import bmls_pkg::*;

  localparam int RANDOM_ITEMS   = 1780;
  localparam int CALM_FROM      = 1580;
  localparam int HOLD_AT        = 700;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  op_t         in_operation  = OP_LBU;
  logic [31:0] in_address    = '0;
  logic [31:0] in_write_data = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [31:0] out_read_data;
  logic        out_out_of_range;

  int fail_count;
  int pending;
  int result_count;
  int oor_count;

  int   gap_pct      = 20;
  bit   hold_request = 1'b0;
  int   n_loads      = 0;
  int   n_stores     = 0;
  int   stall_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_memory_load_store DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_out_of_range (out_out_of_range)
  );

  mem_access_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_out_of_range (out_out_of_range),
    .fail_count       (fail_count),
    .pending          (pending),
    .result_count     (result_count),
    .oor_count        (oor_count)
  );

  // Offer one access beat, optionally after an idle burst, and wait until it is taken.
  task automatic send_access(input op_t op, input logic [31:0] addr,
                             input logic [31:0] data);
    if ($urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_address    <= addr;
    in_write_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_SB || op == OP_SH || op == OP_SW) n_stores++;
    else n_loads++;
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  always begin : result_sink
    int burst;
    @(posedge clk);
    if (hold_request) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_stall <= 1'b0;
      hold_request = 1'b0;
    end else if (rst_n && $urandom_range(1, 100) <= gap_pct) begin
      burst = $urandom_range(1, 16);
      out_stall <= 1'b1;
      repeat (burst) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int          roll;
    logic [31:0] addr;
    logic [31:0] last_store_addr;
    op_t         op;
    last_store_addr = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset fill, sign extension, unaligned, edge of memory, wrap
    send_access(OP_LW,  32'd0,          32'h0);
    send_access(OP_LB,  32'd1,          32'h0);
    send_access(OP_SW,  32'd0,          32'h8001_7f80);
    send_access(OP_LBU, 32'd0,          32'h0);
    send_access(OP_LB,  32'd0,          32'h0);
    send_access(OP_LB,  32'd1,          32'h0);
    send_access(OP_LHU, 32'd0,          32'h0);
    send_access(OP_LH,  32'd0,          32'h0);
    send_access(OP_LH,  32'd2,          32'h0);
    send_access(OP_LW,  32'd0,          32'h0);
    send_access(OP_SH,  32'd3,          32'hdead_beef);
    send_access(OP_LW,  32'd1,          32'h0);
    send_access(OP_LHU, 32'd3,          32'h0);
    send_access(OP_SB,  32'd4095,       32'hffff_ff12);
    send_access(OP_LHU, 32'd4095,       32'h0);
    send_access(OP_SW,  32'd4094,       32'h1122_3344);
    send_access(OP_LW,  32'd4094,       32'h0);
    send_access(OP_LW,  32'hffff_ffff,  32'h0);
    send_access(OP_SW,  32'hffff_fffe,  32'hcafe_f00d);
    send_access(OP_LW,  32'd0,          32'h0);
    send_access(OP_SB,  32'hffff_ffff,  32'hffff_ffff);
    send_access(OP_LBU, 32'hffff_ffff,  32'h0);
    send_access(OP_LW,  32'h8000_0000,  32'h0);
    send_access(OP_SW,  32'd4,          32'hffff_ffff);
    send_access(OP_LW,  32'd4,          32'h0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= CALM_FROM) gap_pct = 0;
      else if (i % 100 == 0) gap_pct = (i / 100 % 3 == 0) ? 0 : (i / 100 % 3 == 1) ? 10 : 35;
      if (i == HOLD_AT) hold_request = 1'b1;
      op   = op_t'($urandom_range(0, 7));
      roll = $urandom_range(0, 99);
      // cluster addresses so loads mostly read back earlier stores
      if (roll < 40)      addr = 32'($urandom_range(0, 63));
      else if (roll < 55) addr = last_store_addr + 32'($urandom_range(0, 3));
      else if (roll < 70) addr = 32'($urandom_range(0, 4095));
      else if (roll < 80) addr = 32'd4088 + 32'($urandom_range(0, 15));
      else if (roll < 90) addr = 32'hffff_fff8 + 32'($urandom_range(0, 7));
      else                addr = $urandom();
      if (op == OP_SB || op == OP_SH || op == OP_SW) last_store_addr = addr;
      send_access(op, addr, $urandom());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);

    $display("Covered %0d accesses (%0d loads, %0d stores); %0d results checked, %0d out of range",
             n_loads + n_stores, n_loads, n_stores, result_count, oor_count);
    $display("Result side held off once for %0d cycles with accesses still offered",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
